/* design/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the substring counter: item structs,
// register indexes and field widths.
// ----------------------------------------------------------------------------
package kmp_pkg;

   // pattern storage in the register file
   localparam int PAT_BYTES           = 32;
   localparam int PAT_REGS            = 4;
   localparam int PAT_REG_W           = 64;
   localparam int MAX_PATTERN_DEFAULT = 32;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_CFG_W   = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES3 = 3'd4;

   localparam int COUNT_W = 32;

   // input item
   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_of_text;
   } req_type;

   // result item
   typedef struct packed {
      logic               match_here;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

endpackage

/* design/kmp_substring_counter.sv */
// ----------------------------------------------------------------------------
// kmp_substring_counter
// Streaming substring counter: text bytes run through a failure-link
// automaton for a configurable pattern; overlapping occurrences count.
// ----------------------------------------------------------------------------
// One text byte per item. A single pattern-byte selector and 8-bit compare
// is shared by a small sequencer, and the failure table sits in a one-port
// memory with registered read data, so each fallback along a link passes
// through a wait state. An accepted item runs start, compare (again after
// each fallback), a link read when an occurrence ends at the byte, and last
// output, which hands the result on once the output register is free. After
// reset or a write to a known register the first item first rebuilds the
// table: a load and a compare per pattern position beyond the first, plus a
// wait per fallback. req_stall is high whenever the sequencer is busy; a
// finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module kmp_substring_counter #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  kmp_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output kmp_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [kmp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [kmp_pkg::CSR_DATA_W-1:0]       csr_data
);
   import kmp_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int DEPTH = MAX_PATTERN + 1;

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BLOADC = 4'd1;
   localparam logic [3:0] S_BCMP   = 4'd2;
   localparam logic [3:0] S_BWAIT  = 4'd3;
   localparam logic [3:0] S_MSTART = 4'd4;
   localparam logic [3:0] S_MCMP   = 4'd5;
   localparam logic [3:0] S_MWAIT  = 4'd6;
   localparam logic [3:0] S_MFAIL  = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   // configuration registers
   logic [LEN_CFG_W-1:0]               len_ff;
   logic [PAT_REGS-1:0][PAT_REG_W-1:0] pat_ff;
   logic                               stale_ff, stale_in;

   // sequencer registers
   logic [3:0]         state_ff, state_in;
   logic [7:0]         text_ff, text_in;
   logic               start_ff, start_in;
   logic [7:0]         pc_ff, pc_in;
   logic [LEN_W-1:0]   i_ff, i_in;
   logic [LEN_W-1:0]   j_ff, j_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic [LEN_W-1:0]   matched_ff, matched_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // failure table memory
   logic [LEN_W-1:0]   links_mem [DEPTH];
   logic [LEN_W-1:0]   rd_data_ff;
   logic               mem_we, mem_re;
   logic [LEN_W-1:0]   mem_wa, mem_wd, mem_ra;

   // shared pattern byte selector and compare
   logic [LEN_W-1:0]   sel;
   logic [7:0]         sel_byte;
   logic [7:0]         cmp_operand;
   logic               cmp_eq;
   logic [LEN_W-1:0]   m_len;
   logic [LEN_W-1:0]   step_sum;

   // active pattern length, clamped to one and to the table size
   always_comb begin
      if (len_ff == '0) begin
         m_len = LEN_W'(1);
      end else if (32'(len_ff) > MAX_PATTERN) begin
         m_len = LEN_W'(MAX_PATTERN);
      end else begin
         m_len = LEN_W'(len_ff);
      end
   end

   // byte selector: positions past the register file read as zero
   always_comb begin
      logic [4:0] bidx;
      bidx = 5'(sel);
      if (32'(sel) >= PAT_BYTES) begin
         sel_byte = 8'h00;
      end else begin
         sel_byte = pat_ff[bidx[4:3]][{bidx[2:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      case (state_ff)
         S_BLOADC: sel = LEN_W'(i_ff - LEN_W'(1));
         S_BCMP:   sel = j_ff;
         default:  sel = k_ff;
      endcase
      cmp_operand = (state_ff == S_BCMP) ? pc_ff : text_ff;
      cmp_eq      = (sel_byte == cmp_operand);
      step_sum    = sel + LEN_W'(cmp_eq);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_CFG_W'(1);
         pat_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PATTERN_LENGTH: len_ff    <= csr_data[LEN_CFG_W-1:0];
            REG_PATTERN_BYTES0: pat_ff[0] <= csr_data;
            REG_PATTERN_BYTES1: pat_ff[1] <= csr_data;
            REG_PATTERN_BYTES2: pat_ff[2] <= csr_data;
            REG_PATTERN_BYTES3: pat_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      text_in      = text_ff;
      start_in     = start_ff;
      pc_in        = pc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      matched_in   = matched_ff;
      total_in     = total_ff;
      hit_in       = hit_ff;
      stale_in     = stale_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               text_in  = req_data.text_byte;
               start_in = req_data.start_of_text;
               if (stale_ff) begin
                  // start rebuild: link of length one is empty
                  mem_we = 1'b1;
                  mem_wa = LEN_W'(1);
                  mem_wd = '0;
                  j_in   = '0;
                  i_in   = LEN_W'(2);
                  if (m_len < LEN_W'(2)) begin
                     stale_in   = 1'b0;
                     matched_in = '0;
                     state_in   = S_MSTART;
                  end else begin
                     state_in = S_BLOADC;
                  end
               end else begin
                  state_in = S_MSTART;
               end
            end
         end
         // build: latch pattern byte i-1
         S_BLOADC: begin
            pc_in    = sel_byte;
            state_in = S_BCMP;
         end
         // build: extend j or fall back along its link
         S_BCMP: begin
            if (j_ff != '0 && !cmp_eq) begin
               mem_re   = 1'b1;
               mem_ra   = j_ff;
               state_in = S_BWAIT;
            end else begin
               mem_we = 1'b1;
               mem_wa = i_ff;
               mem_wd = step_sum;
               j_in   = step_sum;
               if (i_ff == m_len) begin
                  stale_in   = 1'b0;
                  matched_in = '0;
                  state_in   = S_MSTART;
               end else begin
                  i_in     = LEN_W'(i_ff + LEN_W'(1));
                  state_in = S_BLOADC;
               end
            end
         end
         S_BWAIT: begin
            j_in     = rd_data_ff;
            state_in = S_BCMP;
         end
         // match: apply start of text and pick up the matched length
         S_MSTART: begin
            if (start_ff) begin
               total_in = '0;
               k_in     = '0;
            end else if (matched_ff >= m_len) begin
               k_in = '0;
            end else begin
               k_in = matched_ff;
            end
            state_in = S_MCMP;
         end
         // match: extend k or fall back along its link
         S_MCMP: begin
            if (k_ff != '0 && !cmp_eq) begin
               mem_re   = 1'b1;
               mem_ra   = k_ff;
               state_in = S_MWAIT;
            end else if (step_sum >= m_len) begin
               hit_in = 1'b1;
               if (total_ff != '1) begin
                  total_in = total_ff + COUNT_W'(1);
               end
               mem_re   = 1'b1;
               mem_ra   = m_len;
               state_in = S_MFAIL;
            end else begin
               hit_in   = 1'b0;
               k_in     = step_sum;
               state_in = S_OUT;
            end
         end
         S_MWAIT: begin
            k_in     = rd_data_ff;
            state_in = S_MCMP;
         end
         // full match: continue from the link of the whole pattern
         S_MFAIL: begin
            k_in     = rd_data_ff;
            state_in = S_OUT;
         end
         // hand the item to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.match_here  = hit_ff;
               rsp_in.match_count = total_ff;
               matched_in         = k_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // any write to a known register marks the table stale
      if (csr_write_enable && csr_index <= REG_PATTERN_BYTES3) begin
         stale_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stale_ff     <= 1'b1;
         matched_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         matched_ff   <= matched_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      text_ff  <= text_in;
      start_ff <= start_in;
      pc_ff    <= pc_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      hit_ff   <= hit_in;
      rsp_ff   <= rsp_in;
   end

   // failure table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         links_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= links_mem[mem_ra];
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a reported occurrence always has a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.match_here || rsp_data.match_count != '0))
      else $error("match flagged with zero count");

   // a built table leaves the matched length below the pattern length
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !stale_ff) |-> (matched_ff < m_len))
      else $error("matched length out of range");

   // build indexes stay ordered within the pattern
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BCMP) |-> (i_ff >= LEN_W'(2) && i_ff <= m_len && j_ff < i_ff))
      else $error("build index out of range");

   // matching runs on a current table with a partial match only
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MCMP) |-> (!stale_ff && k_ff < m_len))
      else $error("match state out of range");

endmodule
